FILE: rtl/lapc_pkg.sv
// Shared types, widths and reset values for the load-aware pause controller.
// Used by every module under rtl; depends on nothing.
`default_nettype none

package lapc_pkg;

    localparam int TIME_W  = 27;
    localparam int USAGE_W = 10;
    localparam int DELAY_W = 22;
    localparam int IDX_W   = 2;

    localparam int IN_TDATA_W  = 56;
    localparam int OUT_TDATA_W = 8;

    localparam logic [USAGE_W-1:0] THRESHOLD_RST = USAGE_W'(250);
    localparam logic [DELAY_W-1:0] DELAY_RST     = DELAY_W'(10000);

    typedef enum logic [IDX_W-1:0] {
        REG_CPU_EN   = 2'd0,
        REG_BAT_EN   = 2'd1,
        REG_THRESH   = 2'd2,
        REG_DELAY    = 2'd3
    } reg_idx_t;

    typedef enum logic [1:0] {
        ACT_NONE   = 2'd0,
        ACT_PAUSE  = 2'd1,
        ACT_RESUME = 2'd2
    } action_t;

    typedef struct packed {
        logic               cpu_saving_enable;
        logic               battery_saving_enable;
        logic [USAGE_W-1:0] usage_threshold;
        logic [DELAY_W-1:0] confirm_delay_ms;
    } cfg_t;

    typedef struct packed {
        logic              paused_flag;
        logic              cpu_pending;
        logic              battery_pending;
        logic [TIME_W-1:0] cpu_mark_ms;
        logic [TIME_W-1:0] battery_mark_ms;
    } state_t;

    typedef struct packed {
        logic               charging;
        logic               usage_ready;
        logic [USAGE_W-1:0] usage_short;
        logic [USAGE_W-1:0] usage_long;
        logic [TIME_W-1:0]  time_of_day_ms;
    } item_t;

    typedef struct packed {
        action_t action;
        logic    is_paused;
    } result_t;

endpackage

`default_nettype wire

FILE: rtl/lapc_cfg_regs.sv
// Configuration register file for the load-aware pause controller.
// Depends on lapc_pkg.
`default_nettype none

module lapc_cfg_regs
    import lapc_pkg::*;
(
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                cfg_valid,
    output logic                     cfg_ready,
    input  wire logic [IDX_W-1:0]    cfg_index,
    input  wire logic [DELAY_W-1:0]  cfg_data,
    output cfg_t                     cfg
);

    cfg_t cfg_reg;
    cfg_t cfg_next;

    assign cfg_ready = 1'b1;
    assign cfg       = cfg_reg;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_valid)
        begin
            case (reg_idx_t'(cfg_index))
                REG_CPU_EN: cfg_next.cpu_saving_enable     = cfg_data[0];
                REG_BAT_EN: cfg_next.battery_saving_enable = cfg_data[0];
                REG_THRESH: cfg_next.usage_threshold       = cfg_data[USAGE_W-1:0];
                REG_DELAY:  cfg_next.confirm_delay_ms      = cfg_data;
                default:    cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.cpu_saving_enable     <= 1'b0;
            cfg_reg.battery_saving_enable <= 1'b0;
            cfg_reg.usage_threshold       <= THRESHOLD_RST;
            cfg_reg.confirm_delay_ms      <= DELAY_RST;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

endmodule

`default_nettype wire

FILE: rtl/lapc_eval.sv
// Tick evaluation: next trigger state, paused flag and action for one check tick.
// Purely combinational; depends on lapc_pkg.
`default_nettype none

module lapc_eval
    import lapc_pkg::*;
(
    input  wire cfg_t   cfg,
    input  wire state_t st,
    input  wire item_t  item,
    output state_t      st_next,
    output result_t     res
);

    logic [TIME_W:0] cpu_diff;
    logic [TIME_W:0] bat_diff;
    logic            cpu_passed;
    logic            bat_passed;
    logic            long_high;
    logic            short_high;
    logic            cpu_fire;
    logic            cpu_arm;
    logic            cpu_mid;
    logic            bat_mid;
    logic            bat_fire;
    logic            bat_arm;
    logic            both;
    logic            resume;
    logic            arm_both;

    assign cpu_diff = {1'b0, item.time_of_day_ms} - {1'b0, st.cpu_mark_ms};
    assign bat_diff = {1'b0, item.time_of_day_ms} - {1'b0, st.battery_mark_ms};

    assign cpu_passed = !cpu_diff[TIME_W] &&
                        (cpu_diff[TIME_W-1:0] > TIME_W'(cfg.confirm_delay_ms));
    assign bat_passed = !bat_diff[TIME_W] &&
                        (bat_diff[TIME_W-1:0] > TIME_W'(cfg.confirm_delay_ms));

    assign long_high  = item.usage_long  > cfg.usage_threshold;
    assign short_high = item.usage_short > cfg.usage_threshold;

    assign cpu_fire = st.cpu_pending && cpu_passed && short_high;
    assign cpu_arm  = !st.cpu_pending && cfg.cpu_saving_enable && item.usage_ready
                      && long_high;
    assign cpu_mid  = cpu_fire ? 1'b0 : (st.cpu_pending || cpu_arm);
    assign bat_mid  = cpu_fire ? 1'b0 : st.battery_pending;

    assign bat_fire = bat_mid && bat_passed && !item.charging;
    assign bat_arm  = !bat_mid && cfg.battery_saving_enable && !item.charging;

    assign both     = st.cpu_pending && st.battery_pending;
    assign resume   = both && cpu_passed && !short_high && item.charging;
    assign arm_both = !both && !long_high && item.charging;

    always_comb
    begin
        st_next    = st;
        res.action = ACT_NONE;
        if (!st.paused_flag)
        begin
            st_next.cpu_pending     = bat_fire ? 1'b0 : cpu_mid;
            st_next.battery_pending = bat_fire ? 1'b0 : (bat_mid || bat_arm);
            if (cpu_arm)
            begin
                st_next.cpu_mark_ms = item.time_of_day_ms;
            end
            if (bat_arm)
            begin
                st_next.battery_mark_ms = item.time_of_day_ms;
            end
            if (cpu_fire || bat_fire)
            begin
                st_next.paused_flag = 1'b1;
                res.action          = ACT_PAUSE;
            end
        end
        else if (resume)
        begin
            st_next.cpu_pending     = 1'b0;
            st_next.battery_pending = 1'b0;
            st_next.paused_flag     = 1'b0;
            res.action              = ACT_RESUME;
        end
        else if (arm_both)
        begin
            st_next.cpu_pending     = 1'b1;
            st_next.battery_pending = 1'b1;
            st_next.cpu_mark_ms     = item.time_of_day_ms;
            st_next.battery_mark_ms = item.time_of_day_ms;
        end
        res.is_paused = st_next.paused_flag;
    end

endmodule

`default_nettype wire

FILE: rtl/load_aware_pause_controller_core.sv
// Top level of the load-aware pause controller: input register, tick evaluation,
// controller state and result register. Depends on lapc_pkg, lapc_cfg_regs, lapc_eval.
`default_nettype none

// Each check tick yields exactly one result carrying the paused flag and the action
// taken (none, pause, resume). A tick is held in an input register, evaluated against
// the controller state and written to the result register, so a new tick is taken
// every cycle unless stalled; the result is valid once it has passed both registers.
// Ticks stall only while the result register is full and the downstream side holds
// tready low. Configuration writes are taken at any time and should be made between ticks.

module load_aware_pause_controller_core
    import lapc_pkg::*;
(
    input  wire logic                   clk,
    input  wire logic                   rst_n,

    input  wire logic                   s_axis_tvalid,
    output logic                        s_axis_tready,
    // [26:0] time_of_day_ms, [36:27] usage_long, [46:37] usage_short,
    // [47] usage_ready, [48] charging, [55:49] zero
    input  wire logic [IN_TDATA_W-1:0]  s_axis_tdata,

    output logic                        m_axis_tvalid,
    input  wire logic                   m_axis_tready,
    // [0] is_paused, [2:1] action, [7:3] zero
    output logic [OUT_TDATA_W-1:0]      m_axis_tdata,

    input  wire logic                   cfg_valid,
    output logic                        cfg_ready,
    input  wire logic [IDX_W-1:0]       cfg_index,
    input  wire logic [DELAY_W-1:0]     cfg_data
);

    localparam int ITEM_W = $bits(item_t);
    localparam int RES_W  = $bits(result_t);

    cfg_t    cfg;
    item_t   item_reg;
    logic    in_valid_reg;
    result_t res_reg;
    result_t res_next;
    logic    out_valid_reg;
    state_t  st_reg;
    state_t  st_next;
    logic    advance;
    logic    take_in;

    lapc_cfg_regs u_cfg_regs (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    lapc_eval u_eval (
        .cfg     (cfg),
        .st      (st_reg),
        .item    (item_reg),
        .st_next (st_next),
        .res     (res_next)
    );

    assign advance       = in_valid_reg && (!out_valid_reg || m_axis_tready);
    assign s_axis_tready = !in_valid_reg || advance;
    assign take_in       = s_axis_tvalid && s_axis_tready;

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {(OUT_TDATA_W - RES_W)'(0), res_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            st_reg        <= '0;
        end
        else
        begin
            if (take_in)
            begin
                in_valid_reg <= 1'b1;
            end
            else if (advance)
            begin
                in_valid_reg <= 1'b0;
            end

            if (advance)
            begin
                out_valid_reg <= 1'b1;
                st_reg        <= st_next;
            end
            else if (m_axis_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (take_in)
        begin
            item_reg <= item_t'(s_axis_tdata[ITEM_W-1:0]);
        end
        if (advance)
        begin
            res_reg <= res_next;
        end
    end

endmodule

`default_nettype wire
